### rtl/core/bidirectional_flow_table_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bidirectional flow table core
// Shared wrappers that clock on clk and hold off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef BIDIRECTIONAL_FLOW_TABLE_CORE_ASSERT_SVH
`define BIDIRECTIONAL_FLOW_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define BFT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BFT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/bft_pkg.sv
// ---------------------------------------------------------------------------
// bft_pkg
// Types, codes and constants shared by the flow table controller, datapath
// and top level.
// ---------------------------------------------------------------------------
package bft_pkg;

	localparam int FLOW_ENTRIES_DEF = 64;

	localparam int S_TDATA_W = 104;
	localparam int M_TDATA_W = 24;
	localparam int RESULT_W  = 17;

	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;
	localparam logic [7:0] PROTO_ICMP = 8'd1;

	localparam logic [1:0] CLASS_TCP   = 2'd0;
	localparam logic [1:0] CLASS_UDP   = 2'd1;
	localparam logic [1:0] CLASS_ICMP  = 2'd2;
	localparam logic [1:0] CLASS_OTHER = 2'd3;

	localparam logic [1:0] DIR_FORWARD  = 2'd0;
	localparam logic [1:0] DIR_BACKWARD = 2'd1;
	localparam logic [1:0] DIR_UNKNOWN  = 2'd2;

	localparam logic FUNC_PACKET = 1'b0;
	localparam logic FUNC_CLEAR  = 1'b1;

	// input transaction payload, last field in the lowest bits
	typedef struct packed {
		logic [7:0]  proto_byte;
		logic [15:0] dst_port;
		logic [15:0] src_port;
		logic [31:0] dst_ip;
		logic [31:0] src_ip;
	} pkt_t;

	// one table entry
	typedef struct packed {
		logic [1:0]  proto_class;
		logic [15:0] bwd_port;
		logic [31:0] bwd_addr;
		logic [15:0] fwd_port;
		logic [31:0] fwd_addr;
	} entry_t;

	// result transaction payload, last field in the lowest bits
	typedef struct packed {
		logic       table_full;
		logic [6:0] active_flows;
		logic [5:0] flow_index;
		logic       new_flow;
		logic [1:0] direction;
	} result_t;

	typedef struct packed {
		logic capture;
		logic rd_en;
		logic idx_inc;
		logic load_hit;
		logic load_insert;
		logic load_full;
		logic load_clear;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic idx_lt_count;
		logic full;
		logic match;
		logic out_free;
	} ctrl_status_t;

	function automatic logic [1:0] class_of(input logic [7:0] proto);
		logic [1:0] cls;
		case (proto)
			PROTO_TCP:  cls = CLASS_TCP;
			PROTO_UDP:  cls = CLASS_UDP;
			PROTO_ICMP: cls = CLASS_ICMP;
			default:    cls = CLASS_OTHER;
		endcase
		return cls;
	endfunction

endpackage

### rtl/core/bidirectional_flow_table_core.sv
// ---------------------------------------------------------------------------
// bidirectional_flow_table_core
// Five-tuple flow table with direction tracking, one result per transaction.
// ---------------------------------------------------------------------------
// One transaction is in flight at a time. A clear is accepted and then
// loads its result without a scan. A packet header walks the valid entries
// of the flow memory in index order, each entry in a read step and then a
// compare step, so a hit on entry i waits on the entries before it and a
// miss waits on all active flows; the single read port of the entry memory
// sets this pace. The next header is accepted as soon as the current one
// has its result loaded, even while that result still waits on the master
// side. Entries are always filled from index 0 upward and only a clear
// removes them, so the flow count alone says which entries are valid and no
// clearing pass is needed after reset or on a clear.
module bidirectional_flow_table_core #(
	parameter int FLOW_ENTRIES = bft_pkg::FLOW_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave side: one packet header or clear request per transaction
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [31:0] src_ip, [63:32] dst_ip, [79:64] src_port, [95:80] dst_port,
	// [103:96] proto_byte
	input  logic [bft_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// [0] func (0 process header, 1 clear all flows)
	input  logic                          s_axis_tuser,
	// master side: one result per transaction
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [1:0] direction, [2] new_flow, [8:3] flow_index, [15:9] active_flows,
	// [16] table_full, [23:17] zero
	output logic [bft_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import bft_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t st;

	// sequencer: accept, scan, decide
	bft_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.st      (st),
		.cmd     (cmd)
	);

	// entry memory, match logic, flow count and output register
	bft_datapath #(
		.FLOW_ENTRIES (FLOW_ENTRIES)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_data  (s_axis_tdata),
		.s_func  (s_axis_tuser),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_data  (m_axis_tdata),
		.cmd     (cmd),
		.st      (st)
	);

endmodule

### rtl/core/bft_ctrl.sv
// ---------------------------------------------------------------------------
// bft_ctrl
// Sequencer for one transaction: capture, then either a clear result or a
// scan of the valid entries followed by a hit, insert or full result.
// ---------------------------------------------------------------------------
module bft_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_valid,
	output logic                  s_ready,
	input  bft_pkg::ctrl_status_t st,
	output bft_pkg::ctrl_cmd_t    cmd
);
	import bft_pkg::*;

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_LOOKUP  = 2'd1;
	localparam logic [1:0] ST_COMPARE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		s_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (st.is_clear) begin
					if (st.out_free) begin
						cmd.load_clear = 1'b1;
						state_d        = ST_IDLE;
					end
				end else if (st.idx_lt_count) begin
					cmd.rd_en = 1'b1;
					state_d   = ST_COMPARE;
				end else if (st.out_free) begin
					// end of the valid entries: no match
					if (st.full) begin
						cmd.load_full = 1'b1;
					end else begin
						cmd.load_insert = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			ST_COMPARE: begin
				if (st.match) begin
					if (st.out_free) begin
						cmd.load_hit = 1'b1;
						state_d      = ST_IDLE;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_LOOKUP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/bft_datapath.sv
// ---------------------------------------------------------------------------
// bft_datapath
// Packet register, entry memory, scan index, flow count, match logic and
// the output register.
// ---------------------------------------------------------------------------
module bft_datapath #(
	parameter int FLOW_ENTRIES = bft_pkg::FLOW_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [bft_pkg::S_TDATA_W-1:0]  s_data,
	input  logic                           s_func,
	output logic                           m_valid,
	input  logic                           m_ready,
	output logic [bft_pkg::M_TDATA_W-1:0]  m_data,
	input  bft_pkg::ctrl_cmd_t             cmd,
	output bft_pkg::ctrl_status_t          st
);
	import bft_pkg::*;

	localparam int IDX_W = $clog2(FLOW_ENTRIES);
	localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FLOW_ENTRIES);

	pkt_t              pkt_q;
	logic              func_q;
	logic [1:0]        cls_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_inc;
	entry_t            mem_q [FLOW_ENTRIES];
	entry_t            rd_q;
	entry_t            wr_entry;
	logic              m_valid_q;
	result_t           res_q;
	result_t           res_d;
	logic              fwd_hit;
	logic              bwd_hit;
	logic              out_free;
	logic [31:0]       idx_wide;
	logic [31:0]       cnt_wide;
	logic [31:0]       cnt_inc_wide;

	assign count_inc    = count_q + 1'b1;
	assign idx_wide     = 32'(idx_q);
	assign cnt_wide     = 32'(count_q);
	assign cnt_inc_wide = 32'(count_inc);

	// capture the header
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pkt_q  <= pkt_t'(s_data);
			func_q <= s_func;
			cls_q  <= class_of(s_data[S_TDATA_W-1 -: 8]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.capture) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// entries below the count are the valid ones: inserts fill in order and
	// only a clear takes entries away
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load_clear) begin
			count_q <= '0;
		end else if (cmd.load_insert) begin
			count_q <= count_inc;
		end
	end

	assign wr_entry = '{
		proto_class: cls_q,
		bwd_port:    pkt_q.dst_port,
		bwd_addr:    pkt_q.dst_ip,
		fwd_port:    pkt_q.src_port,
		fwd_addr:    pkt_q.src_ip
	};

	always_ff @(posedge clk) begin
		if (cmd.load_insert) begin
			mem_q[count_q[IDX_W-1:0]] <= wr_entry;
		end
		if (cmd.rd_en) begin
			rd_q <= mem_q[idx_q[IDX_W-1:0]];
		end
	end

	assign fwd_hit = (rd_q.fwd_addr == pkt_q.src_ip) && (rd_q.fwd_port == pkt_q.src_port) &&
		(rd_q.bwd_addr == pkt_q.dst_ip) && (rd_q.bwd_port == pkt_q.dst_port);
	assign bwd_hit = (rd_q.bwd_addr == pkt_q.src_ip) && (rd_q.bwd_port == pkt_q.src_port) &&
		(rd_q.fwd_addr == pkt_q.dst_ip) && (rd_q.fwd_port == pkt_q.dst_port);

	assign out_free = !m_valid_q || m_ready;

	assign st.is_clear     = (func_q == FUNC_CLEAR);
	assign st.idx_lt_count = (idx_q < count_q);
	assign st.full         = (count_q == CNT_MAX);
	assign st.match        = (rd_q.proto_class == cls_q) && (fwd_hit || bwd_hit);
	assign st.out_free     = out_free;

	always_comb begin
		res_d = '{
			table_full:   1'b0,
			active_flows: 7'd0,
			flow_index:   6'd0,
			new_flow:     1'b0,
			direction:    DIR_UNKNOWN
		};
		if (cmd.load_hit) begin
			res_d.direction    = fwd_hit ? DIR_FORWARD : DIR_BACKWARD;
			res_d.flow_index   = idx_wide[5:0];
			res_d.active_flows = cnt_wide[6:0];
		end else if (cmd.load_insert) begin
			res_d.direction    = DIR_FORWARD;
			res_d.new_flow     = 1'b1;
			res_d.flow_index   = cnt_wide[5:0];
			res_d.active_flows = cnt_inc_wide[6:0];
		end else if (cmd.load_full) begin
			res_d.table_full   = 1'b1;
			res_d.active_flows = cnt_wide[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.load_hit || cmd.load_insert || cmd.load_full || cmd.load_clear) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_hit || cmd.load_insert || cmd.load_full || cmd.load_clear) begin
			res_q <= res_d;
		end
	end

	assign m_valid = m_valid_q;
	assign m_data  = {(M_TDATA_W - RESULT_W)'(0), res_q};

endmodule

### rtl/core/bft_checker.sv
// ---------------------------------------------------------------------------
// bft_checker
// Port-level checks on the flow table core, attached by bind.
// ---------------------------------------------------------------------------
`include "bidirectional_flow_table_core_assert.svh"

module bft_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [bft_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import bft_pkg::*;

	// a result that is not taken holds
	`BFT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

	// one transaction at a time: no acceptance right after an acceptance
	`BFT_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted a second transaction while busy")

	// a new flow is always forward and never a full-table result
	`BFT_ASSERT_NOW(a_new_is_fwd, m_axis_tvalid && m_axis_tdata[2], (m_axis_tdata[1:0] == DIR_FORWARD) && !m_axis_tdata[16], "new flow result not forward")

	// a full-table result carries unknown direction and no insert
	`BFT_ASSERT_NOW(a_full_unknown, m_axis_tvalid && m_axis_tdata[16], (m_axis_tdata[1:0] == DIR_UNKNOWN) && !m_axis_tdata[2] && (m_axis_tdata[8:3] == 6'd0), "full result malformed")

	// unknown direction comes only with a clear or a full table
	`BFT_ASSERT_NOW(a_unknown_src, m_axis_tvalid && (m_axis_tdata[1:0] == DIR_UNKNOWN) && !m_axis_tdata[16], m_axis_tdata[15:3] == 13'd0, "clear result carries nonzero fields")

endmodule

bind bidirectional_flow_table_core bft_checker u_bft_checker (.*);
